// ===== rtl/depth_scaled_box_mean_feature_macros.svh =====
// Assertion macros shared by the box mean feature RTL.
// Expect clk and arst_n in the scope of each use.
`ifndef DEPTH_SCALED_BOX_MEAN_FEATURE_MACROS_SVH
`define DEPTH_SCALED_BOX_MEAN_FEATURE_MACROS_SVH

// Same-cycle implication.
`define DSBM_AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DSBM_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dsbm_pkg.sv =====
// Shared constants, codes and types of the depth scaled box mean feature.
// No dependencies; every other RTL file imports it.
package dsbm_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int BINS        = 8;
	localparam int BIN_W       = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int STORE_DEPTH = BINS * (MAX_WIDTH + 1) * (MAX_HEIGHT + 1);
	localparam int ADDR_W      = 20;
	localparam int XW          = $clog2(MAX_WIDTH);
	localparam int YW          = $clog2(MAX_HEIGHT);
	localparam int BASE_W      = $clog2((MAX_WIDTH + 1) * (MAX_HEIGHT + 1) + 1);
	localparam int AREA_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int WORD_W      = 32;
	localparam int SUM_W       = 34;

	// Divider lane: radix-2 restoring, DIV_BITS quotient bits per stage.
	localparam int DIV_NW     = 36;
	localparam int DIV_DW     = 17;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = DIV_NW / DIV_BITS;
	localparam int LANES      = 4;
	localparam int LN_X       = 0;
	localparam int LN_Y       = 1;
	localparam int LN_W       = 2;
	localparam int LN_H       = 3;

	localparam int S_TDATA_W  = 88;
	localparam int M_TDATA_W  = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X, REG_OFFSET_Y, REG_HALF_WIDTH, REG_HALF_HEIGHT,
		REG_CHANNEL, REG_SCALE_MODE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic [DIV_DW-1:0] den;
		logic [DIV_DW-1:0] rem;
		logic [DIV_NW-1:0] nq;   // numerator bits shift out, quotient bits shift in
	} div_lane_t;

	typedef struct packed {
		logic              op;
		logic              zero;
		logic [ADDR_W-1:0] ld_addr;
		logic [WORD_W-1:0] ld_value;
		logic [XW:0]       col1;
		logic [XW:0]       col2;
		logic [BASE_W-1:0] rb1;
		logic [BASE_W-1:0] rb2;
		logic [AREA_W-1:0] area;
	} fetch_req_t;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;  // two's complement box sum
		logic [AREA_W-1:0] area;
		logic              zero;
	} fetch_rsp_t;

endpackage

// ===== rtl/depth_scaled_box_mean_feature.sv =====
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata fields, s_tuser operation
// m_*       out  m_tvalid/m_tready    m_tdata patch_mean, m_tuser status
// cfg_*     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Loads pass at one per cycle while nothing downstream stalls; a query holds the store's read
// sequencer for its four reads (one read per integral corner), blocking new requests until its last read.
// A query result reaches m_tvalid through entry, 9 scaling divider stages, the corner stages,
// store handoff, 4 reads, sum, mean entry, 9 mean divider stages and the output register.
// Reset clears valids and sets config to defaults (image 256 by 256, rest zero); the store holds garbage until loaded.
// Each stage advances when its successor has room, so a stall drops nothing.
// Depends on dsbm_pkg, dsbm_div_step, dsbm_fetch and the assertion macro header.
`include "depth_scaled_box_mean_feature_macros.svh"
module depth_scaled_box_mean_feature (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [19:0] load_address, [51:20] load_value, [59:52] pixel_x,
	// [67:60] pixel_y, [83:68] depth_mm, [87:84] zero
	input  logic [dsbm_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [0:0]                        s_tuser,  // [0] operation
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [dsbm_pkg::M_TDATA_W-1:0]    m_tdata,  // [33:0] patch_mean, [39:34] zero
	output logic [0:0]                        m_tuser,  // [0] status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dsbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dsbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dsbm_pkg::*;

	localparam int CW = 21;   // signed center and extent width
	localparam int LD = DIV_STAGES - 1;

	typedef struct packed {
		logic              op;
		logic              zero;
		logic [ADDR_W-1:0] ld_addr;
		logic [WORD_W-1:0] ld_value;
		logic              neg_x;
		logic              neg_y;
	} front_sb_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} mean_sb_t;

	// configuration
	logic signed [8:0] offset_x_q, offset_y_q;
	logic [7:0]        half_width_q, half_height_q;
	logic [3:0]        channel_q;
	logic              scale_q;
	logic [8:0]        image_width_q, image_height_q;
	logic [8:0]        w_eff, h_eff;
	logic [BIN_W-1:0]  chan_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			half_width_q   <= '0;
			half_height_q  <= '0;
			channel_q      <= '0;
			scale_q        <= 1'b0;
			image_width_q  <= 9'd256;
			image_height_q <= 9'd256;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OFFSET_X:     offset_x_q     <= $signed(cfg_data);
				REG_OFFSET_Y:     offset_y_q     <= $signed(cfg_data);
				REG_HALF_WIDTH:   half_width_q   <= cfg_data[7:0];
				REG_HALF_HEIGHT:  half_height_q  <= cfg_data[7:0];
				REG_CHANNEL:      channel_q      <= cfg_data[3:0];
				REG_SCALE_MODE:   scale_q        <= cfg_data[0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default:          scale_q        <= scale_q;
			endcase
		end
	end

	always_comb begin
		priority if (image_width_q == '0) w_eff = 9'd1;
		else if (image_width_q > 9'(MAX_WIDTH)) w_eff = 9'(MAX_WIDTH);
		else w_eff = image_width_q;
		priority if (image_height_q == '0) h_eff = 9'd1;
		else if (image_height_q > 9'(MAX_HEIGHT)) h_eff = 9'(MAX_HEIGHT);
		else h_eff = image_height_q;
		if (channel_q > 4'(BINS - 1)) chan_eff = BIN_W'(BINS - 1);
		else chan_eff = BIN_W'(channel_q);
	end

	// front: numerators and divisor of the scaled center and extents
	logic [ADDR_W-1:0]  in_addr;
	logic [WORD_W-1:0]  in_value;
	logic [7:0]         in_px, in_py;
	logic [15:0]        in_depth;
	logic               in_zero;
	logic [23:0]        prod_x, prod_y;
	logic signed [19:0] ox_k, oy_k;
	logic signed [25:0] nx, ny;
	logic [25:0]        mag_x, mag_y;
	logic [17:0]        nw, nh;
	logic [DIV_DW-1:0]  den;
	div_lane_t          ln_init [LANES];
	front_sb_t          sb_init;

	assign in_addr  = s_tdata[19:0];
	assign in_value = s_tdata[51:20];
	assign in_px    = s_tdata[59:52];
	assign in_py    = s_tdata[67:60];
	assign in_depth = s_tdata[83:68];

	always_comb begin
		in_zero = scale_q && in_depth == '0;
		prod_x  = 24'(in_px) * 24'(in_depth);
		prod_y  = 24'(in_py) * 24'(in_depth);
		ox_k    = 20'(offset_x_q) * 20'sd1000;
		oy_k    = 20'(offset_y_q) * 20'sd1000;
		if (scale_q) begin
			nx = $signed({2'b0, prod_x}) + 26'(ox_k);
			ny = $signed({2'b0, prod_y}) + 26'(oy_k);
			nw = 18'(half_width_q) * 18'd1000;
			nh = 18'(half_height_q) * 18'd1000;
		end else begin
			nx = $signed({18'b0, in_px}) + 26'(offset_x_q);
			ny = $signed({18'b0, in_py}) + 26'(offset_y_q);
			nw = 18'(half_width_q);
			nh = 18'(half_height_q);
		end
		// divide by one when scaling is off or the depth is missing
		den   = (scale_q && !in_zero) ? DIV_DW'(in_depth) : DIV_DW'(1);
		mag_x = nx[25] ? 26'(-nx) : 26'(nx);
		mag_y = ny[25] ? 26'(-ny) : 26'(ny);
		ln_init[LN_X] = '{den: den, rem: '0, nq: DIV_NW'(mag_x)};
		ln_init[LN_Y] = '{den: den, rem: '0, nq: DIV_NW'(mag_y)};
		ln_init[LN_W] = '{den: den, rem: '0, nq: DIV_NW'(nw)};
		ln_init[LN_H] = '{den: den, rem: '0, nq: DIV_NW'(nh)};
		sb_init = '{op: s_tuser[0], zero: in_zero, ld_addr: in_addr, ld_value: in_value,
			neg_x: nx[25], neg_y: ny[25]};
	end

	// stage registers
	logic              v_s1, v_s3, v_s4, v_s5, a0_v, v_o;
	logic              dv_v [DIV_STAGES];
	logic              av_v [DIV_STAGES];
	div_lane_t         ln_s1 [LANES];
	front_sb_t         sb_s1;
	div_lane_t         dv_ln [DIV_STAGES][LANES];
	front_sb_t         dv_sb [DIV_STAGES];
	div_lane_t         div_in [DIV_STAGES][LANES];
	div_lane_t         div_out [DIV_STAGES][LANES];
	logic signed [CW-1:0] cx_s3, cy_s3, pw_s3, ph_s3;
	front_sb_t         sb_s3, sb_s4;
	logic [XW-1:0]     x1_s4;
	logic [XW:0]       x2p1_s4;
	logic [YW-1:0]     y1_s4;
	logic [YW:0]       y2p1_s4;
	fetch_req_t        req_s5;
	div_lane_t         a0_ln;
	mean_sb_t          a0_sb;
	div_lane_t         av_ln [DIV_STAGES];
	mean_sb_t          av_sb [DIV_STAGES];
	div_lane_t         av_in [DIV_STAGES];
	div_lane_t         av_out [DIV_STAGES];
	logic [SUM_W-1:0]  mean_o;
	logic              status_o;

	// flow control
	logic       en_s1, en_s3, en_s4, en_s5, en_a0, en_o;
	logic       en_dv [DIV_STAGES];
	logic       en_av [DIV_STAGES];
	logic       f_in_ready, f_out_valid;
	fetch_rsp_t f_rsp;

	always_comb begin
		en_o = !v_o || m_tready;
		for (int k = LD; k >= 0; k--) begin
			if (k == LD) en_av[k] = !av_v[k] || en_o;
			else en_av[k] = !av_v[k] || en_av[k+1];
		end
		en_a0 = !a0_v || en_av[0];
		en_s5 = !v_s5 || f_in_ready;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		for (int k = LD; k >= 0; k--) begin
			if (k == LD) en_dv[k] = !dv_v[k] || en_s3;
			else en_dv[k] = !dv_v[k] || en_dv[k+1];
		end
		en_s1 = !v_s1 || en_dv[0];
	end

	assign s_tready = en_s1;

	always_comb begin
		div_in[0] = ln_s1;
		av_in[0]  = a0_ln;
		for (int k = 1; k < DIV_STAGES; k++) begin
			div_in[k] = dv_ln[k-1];
			av_in[k]  = av_ln[k-1];
		end
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			dsbm_div_step u_step (.din(div_in[g][l]), .dout(div_out[g][l]));
		end
		dsbm_div_step u_area (.din(av_in[g]), .dout(av_out[g]));
	end

	function automatic logic [XW-1:0] clamp_c(input logic signed [CW:0] v,
			input logic [XW-1:0] hi);
		if (v < 0) return '0;
		else if (v > $signed({{(CW+1-XW){1'b0}}, hi})) return hi;
		else return v[XW-1:0];
	endfunction

	logic signed [CW:0] lo_x, hi_x, lo_y, hi_y;
	logic [XW-1:0]      x2_c;
	logic [YW-1:0]      y2_c;
	logic [XW-1:0]      x1_c;

	always_comb begin
		lo_x = (CW+1)'(cx_s3) - (CW+1)'(pw_s3);
		hi_x = (CW+1)'(cx_s3) + (CW+1)'(pw_s3);
		lo_y = (CW+1)'(cy_s3) - (CW+1)'(ph_s3);
		hi_y = (CW+1)'(cy_s3) + (CW+1)'(ph_s3);
		x1_c = clamp_c(lo_x, XW'(w_eff - 9'd1));
		x2_c = clamp_c(hi_x, XW'(w_eff - 9'd1));
		y2_c = YW'(clamp_c(hi_y, XW'(h_eff - 9'd1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			a0_v <= 1'b0;
			v_o  <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_v[k] <= 1'b0;
				av_v[k] <= 1'b0;
			end
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_dv[0]) dv_v[0] <= v_s1;
			if (en_av[0]) av_v[0] <= a0_v;
			for (int k = 1; k < DIV_STAGES; k++) begin
				if (en_dv[k]) dv_v[k] <= dv_v[k-1];
				if (en_av[k]) av_v[k] <= av_v[k-1];
			end
			if (en_s3) v_s3 <= dv_v[LD];
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_a0) a0_v <= f_out_valid;
			if (en_o) v_o <= av_v[LD];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ln_s1 <= ln_init;
			sb_s1 <= sb_init;
		end
		if (en_dv[0]) begin
			dv_ln[0] <= div_out[0];
			dv_sb[0] <= sb_s1;
		end
		if (en_av[0]) begin
			av_ln[0] <= av_out[0];
			av_sb[0] <= a0_sb;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (en_dv[k]) begin
				dv_ln[k] <= div_out[k];
				dv_sb[k] <= dv_sb[k-1];
			end
			if (en_av[k]) begin
				av_ln[k] <= av_out[k];
				av_sb[k] <= av_sb[k-1];
			end
		end
		// restore the sign of the truncated centers
		if (en_s3) begin
			cx_s3 <= dv_sb[LD].neg_x ? -$signed({1'b0, dv_ln[LD][LN_X].nq[CW-2:0]})
				: $signed({1'b0, dv_ln[LD][LN_X].nq[CW-2:0]});
			cy_s3 <= dv_sb[LD].neg_y ? -$signed({1'b0, dv_ln[LD][LN_Y].nq[CW-2:0]})
				: $signed({1'b0, dv_ln[LD][LN_Y].nq[CW-2:0]});
			pw_s3 <= $signed({1'b0, dv_ln[LD][LN_W].nq[CW-2:0]});
			ph_s3 <= $signed({1'b0, dv_ln[LD][LN_H].nq[CW-2:0]});
			sb_s3 <= dv_sb[LD];
		end
		if (en_s4) begin
			x1_s4   <= x1_c;
			x2p1_s4 <= (XW+1)'(x2_c) + 1'b1;
			y1_s4   <= YW'(clamp_c(lo_y, XW'(h_eff - 9'd1)));
			y2p1_s4 <= (YW+1)'(y2_c) + 1'b1;
			sb_s4   <= sb_s3;
		end
		if (en_s5) begin
			req_s5.op       <= sb_s4.op;
			req_s5.zero     <= sb_s4.zero;
			req_s5.ld_addr  <= sb_s4.ld_addr;
			req_s5.ld_value <= sb_s4.ld_value;
			req_s5.col1     <= (XW+1)'(x1_s4);
			req_s5.col2     <= x2p1_s4;
			req_s5.rb1      <= BASE_W'(y1_s4) * BASE_W'(w_eff + 9'd1);
			req_s5.rb2      <= BASE_W'(y2p1_s4) * BASE_W'(w_eff + 9'd1);
			req_s5.area     <= AREA_W'(x2p1_s4 - (XW+1)'(x1_s4)) *
				AREA_W'(y2p1_s4 - (YW+1)'(y1_s4));
		end
		if (en_a0) begin
			a0_ln.den <= DIV_DW'(f_rsp.area);
			a0_ln.rem <= '0;
			a0_ln.nq  <= DIV_NW'(f_rsp.sum[SUM_W-1] ? SUM_W'(-f_rsp.sum) : f_rsp.sum);
			a0_sb     <= '{neg: f_rsp.sum[SUM_W-1], zero: f_rsp.zero};
		end
		if (en_o) begin
			priority if (av_sb[LD].zero) mean_o <= '0;
			else if (av_sb[LD].neg) mean_o <= SUM_W'(-av_ln[LD].nq[SUM_W-1:0]);
			else mean_o <= av_ln[LD].nq[SUM_W-1:0];
			status_o <= av_sb[LD].zero;
		end
	end

	dsbm_fetch u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.chan      (chan_eff),
		.in_valid  (v_s5),
		.in_ready  (f_in_ready),
		.in_req    (req_s5),
		.out_valid (f_out_valid),
		.out_ready (en_a0),
		.out_rsp   (f_rsp)
	);

	assign m_tvalid = v_o;
	assign m_tdata  = M_TDATA_W'(mean_o);
	assign m_tuser  = status_o;

	`DSBM_AST_IMPL(a_zero_mean, m_tvalid && m_tuser[0], m_tdata[SUM_W-1:0] == '0, "status set with nonzero mean")
	`DSBM_AST_NEXT(a_take_s1, s_tvalid && s_tready, v_s1, "accepted request lost at entry")
	`DSBM_AST_NEXT(a_take_a0, f_out_valid && en_a0, a0_v, "box sum lost before mean divider")

endmodule

// ===== rtl/dsbm_div_step.sv =====
// One divider stage: DIV_BITS restoring steps on a divider lane.
// Depends on dsbm_pkg.
module dsbm_div_step (
	input  dsbm_pkg::div_lane_t din,
	output dsbm_pkg::div_lane_t dout
);
	import dsbm_pkg::*;

	always_comb begin
		logic [DIV_DW:0]   t;
		logic [DIV_DW-1:0] r;
		logic [DIV_NW-1:0] nq;
		r  = din.rem;
		nq = din.nq;
		for (int i = 0; i < DIV_BITS; i++) begin
			t  = {r, nq[DIV_NW-1]};
			nq = {nq[DIV_NW-2:0], 1'b0};
			if (t >= {1'b0, din.den}) begin
				t     = t - {1'b0, din.den};
				nq[0] = 1'b1;
			end
			r = t[DIV_DW-1:0];
		end
		dout.den = din.den;
		dout.rem = r;
		dout.nq  = nq;
	end

endmodule

// ===== rtl/dsbm_fetch.sv =====
// Integral store and read sequencer: one write per in-range load, four reads per query.
// Depends on dsbm_pkg and the assertion macro header.
`include "depth_scaled_box_mean_feature_macros.svh"
module dsbm_fetch (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [dsbm_pkg::BIN_W-1:0] chan,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  dsbm_pkg::fetch_req_t     in_req,
	output logic                     out_valid,
	input  logic                     out_ready,
	output dsbm_pkg::fetch_rsp_t     out_rsp
);
	import dsbm_pkg::*;

	// Corner order: bottom right, bottom left, top right, top left.
	typedef enum logic [1:0] {PH_BR, PH_BL, PH_TR, PH_TL} phase_t;

	logic [WORD_W-1:0] mem [0:STORE_DEPTH-1];

	phase_t            phase_q, rd_ph_q;
	logic              busy_q, rd_v_q, out_v_q;
	fetch_req_t        hold_q;
	logic [AREA_W-1:0] meta_area_q;
	logic              meta_zero_q;
	logic [WORD_W-1:0] rd_data_q;
	logic [SUM_W-1:0]  acc_q;
	fetch_rsp_t        out_rsp_q;

	logic              issue_ok, rd_en, wr_en, accept;
	logic [BASE_W:0]   cell_idx;
	logic [ADDR_W-1:0] raddr;
	logic [SUM_W-1:0]  rd_ext;

	assign issue_ok = !out_v_q || out_ready;
	assign rd_en    = busy_q && issue_ok;
	assign in_ready = !busy_q || (phase_q == PH_TL && issue_ok);
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && in_req.op == OP_LOAD &&
		{1'b0, in_req.ld_addr} < (ADDR_W+1)'(STORE_DEPTH);
	assign rd_ext   = SUM_W'(rd_data_q);

	always_comb begin
		unique case (phase_q)
			PH_BR: cell_idx = (BASE_W+1)'(hold_q.rb2) + (BASE_W+1)'(hold_q.col2);
			PH_BL: cell_idx = (BASE_W+1)'(hold_q.rb2) + (BASE_W+1)'(hold_q.col1);
			PH_TR: cell_idx = (BASE_W+1)'(hold_q.rb1) + (BASE_W+1)'(hold_q.col2);
			PH_TL: cell_idx = (BASE_W+1)'(hold_q.rb1) + (BASE_W+1)'(hold_q.col1);
			default: cell_idx = '0;
		endcase
		raddr = ADDR_W'(ADDR_W'(cell_idx) * ADDR_W'(BINS) + ADDR_W'(chan));
	end

	// Read and write share the edge; a read sees the word from before the write.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[in_req.ld_addr] <= in_req.ld_value;
		if (rd_en)
			rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_BR;
			rd_v_q  <= 1'b0;
			rd_ph_q <= PH_BR;
			out_v_q <= 1'b0;
		end else begin
			rd_v_q <= rd_en;
			if (rd_en) begin
				rd_ph_q <= phase_q;
				phase_q <= phase_t'(phase_q + 2'd1);
			end
			if (accept)
				busy_q <= (in_req.op == OP_QUERY);
			else if (rd_en && phase_q == PH_TL)
				busy_q <= 1'b0;
			if (rd_v_q && rd_ph_q == PH_TL)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			hold_q <= in_req;
		if (rd_en && phase_q == PH_TL) begin
			meta_area_q <= hold_q.area;
			meta_zero_q <= hold_q.zero;
		end
		if (rd_v_q) begin
			unique case (rd_ph_q)
				PH_BR: acc_q <= rd_ext;
				PH_BL, PH_TR: acc_q <= acc_q - rd_ext;
				PH_TL: begin
					out_rsp_q.sum  <= acc_q + rd_ext;
					out_rsp_q.area <= meta_area_q;
					out_rsp_q.zero <= meta_zero_q;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_rsp   = out_rsp_q;

	`DSBM_AST_IMPL(a_slot_free, rd_v_q && rd_ph_q == PH_TL, !out_v_q, "result slot busy at last read")
	`DSBM_AST_NEXT(a_hold_phase, busy_q && !issue_ok, $stable(phase_q), "phase moved while stalled")
	`DSBM_AST_IMPL(a_accept_busy, accept && busy_q, phase_q == PH_TL && rd_en, "request taken mid query")

endmodule

// ===== tb/dsbm_feature_checker.sv =====
// Checker for the depth scaled box mean feature: watches the config, input and result
// channels, keeps its own integral store and registers, and compares every result.
// Depends on dsbm_pkg.
`timescale 1ns / 1ps
module dsbm_feature_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [dsbm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [dsbm_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic [0:0]                      m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [dsbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsbm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              pending
);
	import dsbm_pkg::*;

	typedef struct {
		logic [SUM_W-1:0] mean;
		logic             status;
	} feature_t;

	logic [WORD_W-1:0] integral_words [0:STORE_DEPTH-1];
	feature_t          feature_q[$];

	logic signed [8:0] off_x, off_y;
	logic [7:0]        half_w, half_h;
	logic [3:0]        chan;
	logic              scale_on;
	logic [8:0]        img_w, img_h;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic longint lim(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint word_at(input longint col, input longint row,
			input longint w, input longint c);
		longint idx;
		idx = BINS * (col + row * (w + 1)) + c;
		if (idx >= STORE_DEPTH) return 0;
		return longint'(integral_words[idx]);
	endfunction

	function automatic feature_t box_mean(input logic [7:0] px, input logic [7:0] py,
			input logic [15:0] dep);
		feature_t f;
		longint x, y, d, ox, oy, cx, cy, pw, ph, w, h, c;
		longint x1, x2, y1, y2, sum, area, q;
		f.mean = '0;
		f.status = 1'b0;
		x = px;
		y = py;
		d = dep;
		ox = off_x;
		oy = off_y;
		if (scale_on) begin
			if (d == 0) begin
				f.status = 1'b1;
				return f;
			end
			cx = (x * d + ox * 1000) / d;
			cy = (y * d + oy * 1000) / d;
			pw = (longint'(half_w) * 1000) / d;
			ph = (longint'(half_h) * 1000) / d;
		end else begin
			cx = x + ox;
			cy = y + oy;
			pw = half_w;
			ph = half_h;
		end
		w = lim(img_w, 1, MAX_WIDTH);
		h = lim(img_h, 1, MAX_HEIGHT);
		c = lim(chan, 0, BINS - 1);
		x1 = lim(cx - pw, 0, w - 1);
		x2 = lim(cx + pw, 0, w - 1);
		y1 = lim(cy - ph, 0, h - 1);
		y2 = lim(cy + ph, 0, h - 1);
		sum = word_at(x2 + 1, y2 + 1, w, c) - word_at(x1, y2 + 1, w, c)
			- word_at(x2 + 1, y1, w, c) + word_at(x1, y1, w, c);
		area = (x2 - x1 + 1) * (y2 - y1 + 1);
		if (area < 1) area = 1;
		q = sum / area;
		f.mean = q[SUM_W-1:0];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		feature_t got, want;
		logic [ADDR_W-1:0] addr;
		if (!arst_n) begin
			off_x <= '0;
			off_y <= '0;
			half_w <= '0;
			half_h <= '0;
			chan <= '0;
			scale_on <= 1'b0;
			img_w <= 9'd256;
			img_h <= 9'd256;
			feature_q.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_OFFSET_X:     off_x <= cfg_data;
					REG_OFFSET_Y:     off_y <= cfg_data;
					REG_HALF_WIDTH:   half_w <= cfg_data[7:0];
					REG_HALF_HEIGHT:  half_h <= cfg_data[7:0];
					REG_CHANNEL:      chan <= cfg_data[3:0];
					REG_SCALE_MODE:   scale_on <= cfg_data[0];
					REG_IMAGE_WIDTH:  img_w <= cfg_data;
					REG_IMAGE_HEIGHT: img_h <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_LOAD) begin
					addr = s_tdata[19:0];
					// drop writes beyond the store
					if (addr < STORE_DEPTH) integral_words[addr] = s_tdata[51:20];
				end else begin
					feature_q.push_back(box_mean(s_tdata[59:52], s_tdata[67:60],
						s_tdata[83:68]));
				end
			end
			if (m_tvalid && m_tready) begin
				got.mean = m_tdata[SUM_W-1:0];
				got.status = m_tuser[0];
				if (feature_q.size() == 0) begin
					report($sformatf("unexpected result mean=%h status=%b",
						got.mean, got.status));
				end else begin
					want = feature_q.pop_front();
					if (got.mean !== want.mean)
						report($sformatf("patch_mean %h, predicted %h", got.mean, want.mean));
					if (got.status !== want.status)
						report($sformatf("status %b, predicted %b", got.status, want.status));
				end
			end
			pending = feature_q.size();
		end
	end
endmodule

// ===== tb/depth_scaled_box_mean_feature_tb.sv =====
// Top of the depth scaled box mean feature testbench: clock, reset, stimulus and verdict.
// Depends on dsbm_pkg, the block and dsbm_feature_checker.
`timescale 1ns / 1ps
module depth_scaled_box_mean_feature_tb;
	import dsbm_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatches, pending;

	logic calm = 1'b0;
	logic squeeze = 1'b0;
	logic squeezed = 1'b0;
	int   n_loads = 0, n_queries = 0, n_phases = 0;

	always #4 clk = ~clk;

	depth_scaled_box_mean_feature i_dut (.*);

	dsbm_feature_checker i_checker (.*);

	// receiver: random short stalls, one long hold-off while the sender keeps pushing
	initial begin
		forever begin
			@(negedge clk);
			if (squeeze && !squeezed) begin
				m_tready = 1'b0;
				repeat (300) @(negedge clk);
				squeezed = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
				$display("FAIL depth_scaled_box_mean_feature");
				$finish;
			end
		end
	end

	task automatic write_reg(input reg_idx_t r, input int v);
		cfg_valid = 1'b1;
		cfg_index = r;
		cfg_data = v[8:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send(input logic op, input int unsigned addr, input int unsigned value,
			input int px, input int py, input int dep);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser[0] = op;
		s_tdata = {4'b0, dep[15:0], py[7:0], px[7:0], value, addr[19:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
		if (op == OP_LOAD) n_loads++;
		else n_queries++;
	endtask

	function automatic int unsigned cell_addr(input int col, input int row, input int w,
			input int bin);
		return (col + row * (w + 1)) * BINS + bin;
	endfunction

	function automatic int pick_coord(input int n, input bit zones);
		if (!zones) return $urandom_range(0, n);
		return $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(n - 4, n);
	endfunction

	// query pixel that keeps a small patch inside the loaded corner zones
	function automatic int zone_pixel(input int n);
		return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(n - 3, 255);
	endfunction

	function automatic int pick_depth(input int lo, input int hi);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return lo;
			2: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// wait until all results are in, then cover the tail of a trailing load
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// zones: load only the 5x5 corners of the grid; narrow: keep pixels near the corners
	task automatic run_phase(input int ox, input int oy, input int hw, input int hh,
			input int ch, input int sm, input int w, input int h, input bit zones,
			input bit narrow, input int nq, input int dlo, input int dhi);
		int weff, heff, bin, q, kind;
		weff = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		heff = (h < 1) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
		bin = (ch > BINS - 1) ? BINS - 1 : ch;
		settle();
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_HALF_WIDTH, hw);
		write_reg(REG_HALF_HEIGHT, hh);
		write_reg(REG_CHANNEL, ch);
		write_reg(REG_SCALE_MODE, sm);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		n_phases++;
		for (int row = 0; row <= heff; row++)
			for (int col = 0; col <= weff; col++)
				if (!zones || ((col <= 4 || col >= weff - 4) && (row <= 4 || row >= heff - 4)))
					send(OP_LOAD, cell_addr(col, row, weff, bin), $urandom(),
						$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535));
		q = 0;
		while (q < nq) begin
			if ($urandom_range(0, 99) < 15) begin
				kind = $urandom_range(0, 3);
				send(OP_LOAD,
					(kind == 2) ? $urandom_range(0, STORE_DEPTH - 1) :
					(kind == 3) ? $urandom_range(STORE_DEPTH, (1 << ADDR_W) - 1) :
					cell_addr(pick_coord(weff, zones), pick_coord(heff, zones), weff, bin),
					$urandom(), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 65535));
			end else begin
				send(OP_QUERY, $urandom_range(0, (1 << ADDR_W) - 1), $urandom(),
					narrow ? zone_pixel(weff) : $urandom_range(0, 255),
					narrow ? zone_pixel(heff) : $urandom_range(0, 255),
					pick_depth(dlo, dhi));
				q++;
			end
		end
	endtask

	function automatic int small_half();
		return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
	endfunction

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed corners of the configuration space
		run_phase(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 12, 1, 65535);
		run_phase(-255, 255, 255, 0, 15, 1, 7, 3, 0, 0, 20, 1, 65535);
		run_phase(255, -255, 0, 0, 7, 0, 511, 300, 1, 0, 60, 1, 65535);
		// drain first so the hold-off lands while the next phase keeps sending
		settle();
		squeeze = 1'b1;
		run_phase(0, 0, 255, 255, 2, 0, 256, 256, 1, 0, 80, 1, 65535);
		run_phase(0, 0, 1, 1, 5, 1, 200, 100, 1, 1, 80, 1000, 65535);
		run_phase(0, 0, 255, 255, 1, 1, 256, 256, 1, 0, 80, 1, 1000);
		run_phase(0, 0, 3, 2, 4, 0, 0, 2, 0, 0, 40, 1, 65535);
		// random small images, whole grid loaded
		for (int p = 0; p < 5; p++) begin
			if (p == 4) calm = 1'b1;
			run_phase($urandom_range(0, 510) - 255, $urandom_range(0, 510) - 255,
				small_half(), small_half(), $urandom_range(0, 15), $urandom_range(0, 1),
				$urandom_range(1, 12), $urandom_range(1, 12), 0, 0, 130, 1, 65535);
		end
		settle();
		$display("covered %0d loads and %0d queries over %0d register settings",
			n_loads, n_queries, n_phases);
		$display("including clamped corners, depth scaling, zero depth and a long output stall");
		if (mismatches == 0 && pending == 0) begin
			$display("PASS depth_scaled_box_mean_feature");
		end else begin
			if (pending != 0) $display("%0d predicted results never arrived", pending);
			$display("FAIL depth_scaled_box_mean_feature");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dsbm_pkg.sv
rtl/dsbm_div_step.sv
rtl/dsbm_fetch.sv
rtl/depth_scaled_box_mean_feature.sv
tb/dsbm_feature_checker.sv
tb/depth_scaled_box_mean_feature_tb.sv
